### design/kwh_pkg.sv
// Shared types and defaults for the k-mer window histogram.
// No dependencies; imported by kwh_window, kmer_window_histogram and the testbench.
`default_nettype none

package kwh_pkg;

	localparam int MAX_K_DEF      = 6;
	localparam int COUNT_BITS_DEF = 20;
	localparam int KLEN_BITS      = 3;
	localparam logic [KLEN_BITS-1:0] KLEN_RESET = 3'd1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BASE  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// What the histogram stage does with the entry it has read
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_INC   = 2'd1,
		OP_CLEAR = 2'd2
	} hist_op_t;

	typedef struct packed {
		hist_op_t op;
		logic     clean;
		logic     bad;
	} win_ctrl_t;

endpackage

`default_nettype wire

### design/kwh_hist_mem.sv
// Histogram store: single synchronous RAM, one write and one read port,
// registered read data. Uses nothing from the package.
`default_nettype none

module kwh_hist_mem #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_BITS-1:0] wr_addr,
	input  wire logic [DATA_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_BITS-1:0] rd_addr,
	output logic      [DATA_BITS-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [DATA_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/kwh_window.sv
// Window front end: base decode, rolling k-mer register, priming count and
// window flags. Produces the histogram address and operation per request.
// Depends on kwh_pkg.
`default_nettype none

module kwh_window #(
	parameter int MAX_K = kwh_pkg::MAX_K_DEF,
	localparam int IDX_BITS = 2 * MAX_K
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [1:0]                     command,
	input  wire logic [7:0]                     base_char,
	input  wire logic [IDX_BITS-1:0]            entry_index,
	input  wire logic [kwh_pkg::KLEN_BITS-1:0]  kmer_length,
	output kwh_pkg::win_ctrl_t                  ctrl,
	output logic      [IDX_BITS-1:0]            addr
);

	import kwh_pkg::*;

	localparam int PRIMED_BITS = (MAX_K > 1) ? $clog2(MAX_K) : 1;

	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_UC = 8'h43;
	localparam logic [7:0] CH_LC = 8'h63;
	localparam logic [7:0] CH_UG = 8'h47;
	localparam logic [7:0] CH_LG = 8'h67;
	localparam logic [7:0] CH_UT = 8'h54;
	localparam logic [7:0] CH_LT = 8'h74;
	localparam logic [7:0] CH_UN = 8'h4E;
	localparam logic [7:0] CH_LN = 8'h6E;

	logic [IDX_BITS-1:0]    shift_q, shift_d, shift_next;
	logic [PRIMED_BITS-1:0] primed_q, primed_d;
	logic                   clean_q, clean_d;
	logic                   bad_q, bad_d;

	logic [1:0]             code;
	logic                   is_nuc;
	logic                   is_n;
	logic [KLEN_BITS-1:0]   k_eff;
	logic [KLEN_BITS-1:0]   need;
	logic [IDX_BITS-1:0]    kmask;

	always_comb begin
		code   = 2'd0;
		is_nuc = 1'b0;
		is_n   = 1'b0;
		case (base_char) inside
			CH_UA, CH_LA: begin code = 2'd0; is_nuc = 1'b1; end
			CH_UC, CH_LC: begin code = 2'd1; is_nuc = 1'b1; end
			CH_UG, CH_LG: begin code = 2'd2; is_nuc = 1'b1; end
			CH_UT, CH_LT: begin code = 2'd3; is_nuc = 1'b1; end
			CH_UN, CH_LN: begin is_n = 1'b1; end
			default: begin end
		endcase
	end

	// k of 0 acts as 1, anything above MAX_K as MAX_K
	always_comb begin
		if (kmer_length == '0) begin
			k_eff = KLEN_BITS'(1);
		end else if (int'(kmer_length) > MAX_K) begin
			k_eff = KLEN_BITS'(MAX_K);
		end else begin
			k_eff = kmer_length;
		end
		need = k_eff - KLEN_BITS'(1);
	end

	always_comb begin
		for (int i = 0; i < IDX_BITS; i++) begin
			kmask[i] = (i < 2 * int'(k_eff));
		end
	end

	assign shift_next = IDX_BITS'({shift_q, code});

	always_comb begin
		shift_d  = shift_q;
		primed_d = primed_q;
		clean_d  = clean_q;
		bad_d    = bad_q;
		ctrl.op  = OP_NONE;
		addr     = '0;
		case (cmd_t'(command))
			CMD_START: begin
				shift_d  = '0;
				primed_d = '0;
				clean_d  = 1'b1;
				bad_d    = 1'b0;
			end
			CMD_BASE: begin
				if (is_n) begin
					clean_d = 1'b0;
				end else if (!is_nuc) begin
					bad_d = 1'b1;
				end else begin
					shift_d = shift_next;
					if (KLEN_BITS'(primed_q) < need) begin
						primed_d = primed_q + PRIMED_BITS'(1);
					end else begin
						ctrl.op = OP_INC;
						addr    = shift_next & kmask;
					end
				end
			end
			CMD_READ: begin
				ctrl.op = OP_CLEAR;
				addr    = entry_index;
			end
			default: begin end
		endcase
		ctrl.clean = clean_d;
		ctrl.bad   = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			primed_q <= '0;
			clean_q  <= 1'b1;
			bad_q    <= 1'b0;
		end else if (accept) begin
			shift_q  <= shift_d;
			primed_q <= primed_d;
			clean_q  <= clean_d;
			bad_q    <= bad_d;
		end
	end

endmodule

`default_nettype wire

### design/kmer_window_histogram.sv
// k-mer window histogram. A request accepted at one edge loads valid_s1, the
// stage registers and the RAM read; done_q then registers its result (done high).
// Busy is high the cycle after each accept while the histogram RAM entry read at
// accept is modified and written; no new request is accepted meanwhile.
// Reset: a clearing pass writes zero to all 4^MAX_K entries (4096 at default),
// busy high throughout; configuration writes are taken at any time.
`default_nettype none

module kmer_window_histogram #(
	parameter int MAX_K      = kwh_pkg::MAX_K_DEF,
	parameter int COUNT_BITS = kwh_pkg::COUNT_BITS_DEF,
	localparam int IDX_BITS  = 2 * MAX_K
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    command,
	input  wire logic [7:0]                    base_char,
	input  wire logic [IDX_BITS-1:0]           entry_index,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [kwh_pkg::KLEN_BITS-1:0] cfg_data,
	output logic                               done,
	output logic      [COUNT_BITS-1:0]         count,
	output logic                               window_clean,
	output logic                               bad_char
);

	import kwh_pkg::*;

	logic [KLEN_BITS-1:0]  klen_q;
	logic                  clr_busy_q;
	logic [IDX_BITS-1:0]   clr_addr_q;

	logic                  accept;
	win_ctrl_t             win_ctrl;
	logic [IDX_BITS-1:0]   win_addr;

	logic                  valid_s1;
	hist_op_t              op_s1;
	logic [IDX_BITS-1:0]   addr_s1;
	logic                  clean_s1;
	logic                  bad_s1;

	logic [COUNT_BITS-1:0] rd_data;
	logic                  wr_en;
	logic [IDX_BITS-1:0]   wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic [COUNT_BITS-1:0] inc_val;

	logic                  done_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  clean_q;
	logic                  bad_q;

	assign cfg_ready = 1'b1;
	assign busy      = clr_busy_q | valid_s1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KLEN_RESET;
		end else if (cfg_valid) begin
			klen_q <= cfg_data;
		end
	end

	// clearing pass after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + IDX_BITS'(1);
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	kwh_window #(
		.MAX_K(MAX_K)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.base_char   (base_char),
		.entry_index (entry_index),
		.kmer_length (klen_q),
		.ctrl        (win_ctrl),
		.addr        (win_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= win_ctrl.op;
			addr_s1  <= win_addr;
			clean_s1 <= win_ctrl.clean;
			bad_s1   <= win_ctrl.bad;
		end
	end

	// saturating increment of the entry read at accept
	assign inc_val = (&rd_data) ? rd_data : rd_data + COUNT_BITS'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = '0;
		if (clr_busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
		end else if (valid_s1) begin
			case (op_s1)
				OP_INC:   begin wr_en = 1'b1; wr_data = inc_val; end
				OP_CLEAR: begin wr_en = 1'b1; end
				default:  begin end
			endcase
		end
	end

	kwh_hist_mem #(
		.ADDR_BITS(IDX_BITS),
		.DATA_BITS(COUNT_BITS)
	) u_hist_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (win_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			count_q <= (op_s1 == OP_CLEAR) ? rd_data : '0;
			clean_q <= clean_s1;
			bad_q   <= bad_s1;
		end
	end

	assign done         = done_q;
	assign count        = count_q;
	assign window_clean = clean_q;
	assign bad_char     = bad_q;

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !valid_s1)
		else $error("request in flight during clearing pass");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> !valid_s1)
		else $error("back-to-back request entered histogram stage");

	a_done_follows_stage: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without request in histogram stage");

	a_count_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && count != '0) |-> $past(op_s1 == OP_CLEAR))
		else $error("non-zero count returned for a non-read request");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for kmer_window_histogram: directed and random requests,
// each result compared against an in-bench model of the k-mer histogram.
// Depends on kwh_pkg and the kmer_window_histogram RTL.

module tb_top;
	import kwh_pkg::*;

	localparam int IDX_W        = 2 * MAX_K_DEF;
	localparam int DEPTH        = 1 << IDX_W;
	localparam int CNT_W        = COUNT_BITS_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] NT_A = 2'd0;
	localparam logic [1:0] NT_C = 2'd1;
	localparam logic [1:0] NT_G = 2'd2;
	localparam logic [1:0] NT_T = 2'd3;

	typedef struct {
		logic [CNT_W-1:0] count;
		logic             clean;
		logic             bad;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] command = CMD_START;
	logic [7:0] base_char = 8'd0;
	logic [IDX_W-1:0] entry_index = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [KLEN_BITS-1:0] cfg_data = '0;
	logic done;
	logic [CNT_W-1:0] count;
	logic window_clean;
	logic bad_char;

	kmer_window_histogram DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .base_char(base_char), .entry_index(entry_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .count(count), .window_clean(window_clean), .bad_char(bad_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the block
	logic [KLEN_BITS-1:0] klen_m = KLEN_RESET;
	logic [IDX_W-1:0]     kmer_m = '0;
	logic [2:0]           primed_m = '0;
	logic [CNT_W-1:0]     hist_m [DEPTH];
	logic                 clean_m = 1'b1;
	logic                 bad_m = 1'b0;
	logic [IDX_W-1:0]     last_kmer = '0;
	logic [IDX_W-1:0]     touched [$];

	report_t due_reports [$];
	report_t want;
	int mismatches = 0;
	int cycles = 0;

	function automatic report_t histogram_step(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [IDX_W-1:0] idx);
		report_t r;
		int k;
		logic [1:0] code;
		logic nuc;
		logic [IDX_W-1:0] mask;
		r.count = '0;
		case (cmd)
			CMD_START: begin
				kmer_m = '0;
				primed_m = '0;
				clean_m = 1'b1;
				bad_m = 1'b0;
			end
			CMD_BASE: begin
				nuc = 1'b1;
				code = NT_A;
				case (ch)
					"A", "a": code = NT_A;
					"C", "c": code = NT_C;
					"G", "g": code = NT_G;
					"T", "t": code = NT_T;
					"N", "n": begin
						nuc = 1'b0;
						clean_m = 1'b0;
					end
					default: begin
						nuc = 1'b0;
						bad_m = 1'b1;
					end
				endcase
				if (nuc) begin
					kmer_m = {kmer_m[IDX_W-3:0], code};
					k = (klen_m == 0) ? 1 : ((klen_m > MAX_K_DEF) ? MAX_K_DEF : int'(klen_m));
					if (primed_m < k - 1) begin
						primed_m++;
					end else begin
						mask = IDX_W'((1 << (2 * k)) - 1);
						last_kmer = kmer_m & mask;
						if (hist_m[last_kmer] != '1)
							hist_m[last_kmer]++;
						touched.push_back(last_kmer);
						if (touched.size() > 64)
							void'(touched.pop_front());
					end
				end
			end
			CMD_READ: begin
				r.count = hist_m[idx];
				hist_m[idx] = '0;
			end
			default: ;
		endcase
		r.clean = clean_m;
		r.bad = bad_m;
		return r;
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [IDX_W-1:0] idx);
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		base_char <= ch;
		entry_index <= idx;
		do @(posedge clk); while (busy);
		due_reports.push_back(histogram_step(cmd, ch, idx));
	endtask

	// start low and junk on the request fields meanwhile; a pause of n = 0 does nothing
	task automatic pause(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			command <= 2'($urandom);
			base_char <= 8'($urandom);
			entry_index <= IDX_W'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (due_reports.size() != 0) @(negedge clk);
	endtask

	task automatic write_klen(input logic [KLEN_BITS-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		klen_m = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] random_base();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			case ($urandom_range(0, 7))
				0: return "A";
				1: return "C";
				2: return "G";
				3: return "T";
				4: return "a";
				5: return "c";
				6: return "g";
				default: return "t";
			endcase
		end
		if (r < 94) return (r[0] ? "N" : "n");
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [IDX_W-1:0] read_target();
		if (touched.size() > 0 && $urandom_range(0, 9) < 7)
			return touched[$urandom_range(0, touched.size() - 1)];
		return IDX_W'($urandom);
	endfunction

	task automatic test_char_codes();
		send_request(CMD_START, 8'd0, '0);
		send_request(CMD_BASE, "A", '0);
		send_request(CMD_BASE, "c", '0);
		send_request(CMD_BASE, "G", '0);
		send_request(CMD_BASE, "t", '1);
		send_request(CMD_BASE, "N", '0);
		send_request(CMD_BASE, "x", '0);
		send_request(CMD_UNUSED, "A", '0);
		send_request(CMD_READ, 8'hFF, IDX_W'(0));
		send_request(CMD_READ, 8'd0, IDX_W'(3));
		send_request(CMD_READ, 8'd0, '1);
	endtask

	task automatic test_k_extremes();
		write_klen(3'd0);
		send_request(CMD_BASE, "g", '0);
		send_request(CMD_READ, 8'd0, IDX_W'(2));
		// above the largest k: behaves as the largest
		write_klen(3'd7);
		send_request(CMD_START, 8'd0, '0);
		send_request(CMD_BASE, "A", '0);
		send_request(CMD_BASE, "C", '0);
		send_request(CMD_BASE, "G", '0);
		send_request(CMD_BASE, "T", '0);
		send_request(CMD_BASE, "a", '0);
		send_request(CMD_BASE, "c", '0);
		send_request(CMD_READ, 8'd0, last_kmer);
	endtask

	// priming count stays at its ceiling when k shrinks and grows again
	task automatic test_k_change_mid_window();
		write_klen(3'd2);
		send_request(CMD_BASE, "t", '0);
		send_request(CMD_READ, 8'd0, last_kmer);
		write_klen(3'd6);
		send_request(CMD_BASE, "C", '0);
		send_request(CMD_READ, 8'd0, last_kmer);
	endtask

	// long run of one base into a single entry, then read it out twice
	task automatic test_count_run();
		write_klen(3'd1);
		send_request(CMD_START, 8'd0, '0);
		repeat (40) send_request(CMD_BASE, "A", '0);
		send_request(CMD_READ, 8'd0, IDX_W'(0));
		send_request(CMD_READ, 8'd0, IDX_W'(0));
	endtask

	task automatic test_random_windows();
		logic [KLEN_BITS-1:0] klens [8] = '{3'd1, 3'd6, 3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4};
		int budget;
		int wlen;
		int r;
		bit steady;
		foreach (klens[p]) begin
			write_klen(klens[p]);
			steady = ($urandom_range(0, 3) == 0);
			budget = 175;
			while (budget > 0) begin
				send_request(CMD_START, 8'($urandom), IDX_W'($urandom));
				budget--;
				wlen = $urandom_range(1, 40);
				repeat (wlen) begin
					r = $urandom_range(0, 99);
					if (r < 82) begin
						send_request(CMD_BASE, random_base(), IDX_W'($urandom));
						budget--;
					end else if (r < 97) begin
						send_request(CMD_READ, 8'($urandom), read_target());
						budget--;
					end else if (r < 99) begin
						send_request(CMD_UNUSED, 8'($urandom), IDX_W'($urandom));
					end else begin
						send_request(CMD_START, 8'($urandom), IDX_W'($urandom));
						budget--;
					end
					if (!steady)
						pause(random_gap());
					if ($urandom_range(0, 199) == 0)
						wait_drained();
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_reports.size() == 0) begin
				$display("%0t: result with no request outstanding: count %0d clean %0b bad %0b",
					$time, count, window_clean, bad_char);
				mismatches++;
			end else begin
				want = due_reports.pop_front();
				if (count !== want.count) begin
					$display("%0t: count expected %0d, got %0d", $time, want.count, count);
					mismatches++;
				end
				if (window_clean !== want.clean) begin
					$display("%0t: window_clean expected %0b, got %0b",
						$time, want.clean, window_clean);
					mismatches++;
				end
				if (bad_char !== want.bad) begin
					$display("%0t: bad_char expected %0b, got %0b", $time, want.bad, bad_char);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("kmer_window_histogram: mismatch");
			$finish;
		end
	end

	initial begin
		foreach (hist_m[i]) hist_m[i] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_char_codes();
		test_k_extremes();
		test_k_change_mid_window();
		test_count_run();
		test_random_windows();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("kmer_window_histogram: match");
		else
			$display("kmer_window_histogram: mismatch");
		$finish;
	end

endmodule

### filelist.f
design/kwh_pkg.sv
design/kwh_hist_mem.sv
design/kwh_window.sv
design/kmer_window_histogram.sv
tb/tb_top.sv
